FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared types and codes for the deadline-ordered timer pool.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int NUM_TIMERS = 16;

	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_ALLOC   = 3'd1;
	localparam logic [2:0] MODE_BIND    = 3'd2;
	localparam logic [2:0] MODE_ARM     = 3'd3;
	localparam logic [2:0] MODE_RELEASE = 3'd4;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_EXPIRY = 2'd1;
	localparam logic [1:0] KIND_SWITCH = 2'd2;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_USING = 2'd2;

	localparam logic [31:0] NEVER = 32'hffffffff;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [7:0]  fifo;
		logic [31:0] data;
		logic        grant;
		logic        last;
	} result_t;

endpackage

FILE: rtl/stq_out_reg.sv
// ----------------------------------------------------------------------------
// Sorted timer queue output register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module stq_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  stq_pkg::result_t  din,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output stq_pkg::result_t  dout
);
	import stq_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign out_valid = valid_q;
	assign dout      = data_q;
	assign full      = valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

FILE: rtl/sorted_timer_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted timer queue
// A pool of timers kept in one linked list ordered by deadline.
// ----------------------------------------------------------------------------
// Bind, release and unknown modes finish in the idle state; allocate scans
// the slots one a cycle while the output register is not full; arm walks
// the list once to unlink and once to insert; a tick serves each due entry,
// with a task switch request if the switch slot is due, each result waiting
// for the output register. Results appear in the cycle after they form. One
// item is in work at a time. Reset empties the queue and frees all slots.
module sorted_timer_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [3:0]  timer_slot,
	input  logic [7:0]  fifo_id,
	input  logic [31:0] data_value,
	input  logic [31:0] delay,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [3:0]  result_slot,
	output logic [7:0]  target_fifo,
	output logic [31:0] payload,
	output logic        granted,
	output logic        last_of_run
);
	import stq_pkg::*;

	localparam int SW = $clog2(NUM_TIMERS + 1);
	localparam logic [SW-1:0] NO_SLOT = SW'(NUM_TIMERS);

	typedef enum logic [2:0] {
		S_IDLE, S_ALLOC, S_UNLINK, S_INSERT, S_TICK, S_SWITCH
	} state_t;

	state_t state_q;
	logic [4:0]     tss_q;
	logic [1:0]     status_q [NUM_TIMERS];
	logic [31:0]    expiry_q [NUM_TIMERS];
	logic [31:0]    pay_q [NUM_TIMERS];
	logic [7:0]     fifo_q [NUM_TIMERS];
	logic [SW-1:0]  link_q [NUM_TIMERS];
	logic [SW-1:0]  head_q;
	logic [31:0]    tick_q;
	logic [SW-1:0]  slot_q, cur_q, prev_q, cnt_q;
	logic           sw_q;

	logic    load, full, accept;
	result_t res, dout;

	stq_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .load(load), .din(res), .full(full),
		.out_valid(out_valid), .out_stall(out_stall), .dout(dout)
	);

	assign result_kind = dout.kind;
	assign result_slot = dout.slot;
	assign target_fifo = dout.fifo;
	assign payload     = dout.data;
	assign granted     = dout.grant;
	assign last_of_run = dout.last;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;

	logic        cur_ok, due;
	logic [SW-1:0] cur_next;
	logic [3:0]  cur_i;
	assign cur_ok   = cur_q < NO_SLOT;
	assign cur_i    = cur_q[3:0];
	assign cur_next = link_q[cur_q[SW-2:0]];
	assign due      = cur_ok && (expiry_q[cur_q[SW-2:0]] <= tick_q);

	logic slot_ok;
	assign slot_ok = {1'b0, timer_slot} < 5'(NUM_TIMERS);

	always_comb begin
		load = 1'b0;
		res  = '0;
		unique case (state_q)
			S_ALLOC: begin
				if (!full) begin
					if (status_q[cnt_q[SW-2:0]] == ST_FREE && cnt_q < NO_SLOT) begin
						load = 1'b1; res.grant = 1'b1; res.slot = cnt_q[3:0];
						res.last = 1'b1;
					end else if (cnt_q >= NO_SLOT - 1'b1) begin
						load = 1'b1; res.last = 1'b1;
					end
				end
			end
			S_TICK: begin
				if (!full && due && {1'b0, cur_q} != {1'b0, tss_q[SW-1:0]}
						|| (!full && due && tss_q >= 5'(NUM_TIMERS))) begin
					load = 1'b1; res.kind = KIND_EXPIRY; res.slot = cur_i;
					res.fifo = fifo_q[cur_q[SW-2:0]];
					res.data = pay_q[cur_q[SW-2:0]];
					res.last = !sw_q && !(cur_next < NO_SLOT &&
						expiry_q[cur_next[SW-2:0]] <= tick_q && cnt_q < NO_SLOT - 1'b1);
				end
			end
			S_SWITCH: begin
				if (!full) begin
					load = 1'b1; res.kind = KIND_SWITCH; res.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tss_q   <= 5'd16;
			head_q  <= NO_SLOT;
			tick_q  <= '0;
			sw_q    <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) status_q[i] <= ST_FREE;
		end else begin
			if (cfg_valid && cfg_ready) tss_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_q <= SW'(timer_slot);
						cur_q  <= head_q;
						prev_q <= NO_SLOT;
						cnt_q  <= '0;
						sw_q   <= 1'b0;
						case (mode)
							MODE_TICK: begin
								tick_q  <= tick_q + 32'd1;
								state_q <= S_TICK;
							end
							MODE_ALLOC: state_q <= S_ALLOC;
							MODE_BIND: if (slot_ok) begin
								fifo_q[timer_slot] <= fifo_id;
								pay_q[timer_slot]  <= data_value;
							end
							MODE_ARM: if (slot_ok) begin
								expiry_q[timer_slot] <= delay + tick_q;
								status_q[timer_slot] <= ST_USING;
								state_q <= S_UNLINK;
							end
							MODE_RELEASE: if (slot_ok) status_q[timer_slot] <= ST_FREE;
							default: ;
						endcase
					end
				end
				S_ALLOC: begin
					if (load) begin
						if (res.grant) status_q[cnt_q[SW-2:0]] <= ST_ALLOC;
						state_q <= S_IDLE;
					end else if (!full) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_UNLINK: begin
					if (!cur_ok || cnt_q >= NO_SLOT) begin
						cur_q <= head_q; prev_q <= NO_SLOT; cnt_q <= '0;
						state_q <= S_INSERT;
					end else if (cur_q == slot_q) begin
						if (prev_q == NO_SLOT) head_q <= cur_next;
						else link_q[prev_q[SW-2:0]] <= cur_next;
						cur_q <= (prev_q == NO_SLOT) ? cur_next : head_q;
						prev_q <= NO_SLOT; cnt_q <= '0;
						state_q <= S_INSERT;
					end else begin
						prev_q <= cur_q; cur_q <= cur_next; cnt_q <= cnt_q + 1'b1;
					end
				end
				S_INSERT: begin
					if (!cur_ok || cnt_q >= NO_SLOT ||
							expiry_q[slot_q[SW-2:0]] <= expiry_q[cur_q[SW-2:0]]) begin
						link_q[slot_q[SW-2:0]] <= cur_ok ? cur_q : NO_SLOT;
						if (prev_q == NO_SLOT) head_q <= slot_q;
						else link_q[prev_q[SW-2:0]] <= slot_q;
						state_q <= S_IDLE;
					end else begin
						prev_q <= cur_q; cur_q <= cur_next; cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TICK: begin
					if (!due || cnt_q >= NO_SLOT) begin
						state_q <= sw_q ? S_SWITCH : S_IDLE;
					end else if (!full) begin
						status_q[cur_q[SW-2:0]] <= ST_ALLOC;
						head_q <= cur_next;
						cur_q  <= cur_next;
						cnt_q  <= cnt_q + 1'b1;
						if (!load) sw_q <= 1'b1;
					end
				end
				S_SWITCH: begin
					if (load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: verif/tb_sorted_timer_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives timer requests and ticks with random gaps and back pressure, predicts
// every result word from a behavioral copy of the timer pool, and compares the
// words in order across several task switch slot settings.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	import stq_pkg::*;

	localparam int SLOTS = 16;
	localparam int SETTLE = 80;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [2:0]  mode;
		logic [3:0]  slot;
		logic [7:0]  fifo;
		logic [31:0] data;
		logic [31:0] delay;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  mode;
	logic [3:0]  timer_slot;
	logic [7:0]  fifo_id;
	logic [31:0] data_value;
	logic [31:0] delay;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [3:0]  result_slot;
	logic [7:0]  target_fifo;
	logic [31:0] payload;
	logic        granted;
	logic        last_of_run;

	request_t pending_requests[$];
	result_t  expected_results[$];

	// Behavioral copy of the timer pool.
	logic [1:0]  pool_status[SLOTS];
	logic [31:0] pool_expiry[SLOTS];
	logic [31:0] pool_data[SLOTS];
	logic [7:0]  pool_fifo[SLOTS];
	logic [4:0]  pool_link[SLOTS];
	logic [4:0]  pool_head;
	logic [31:0] pool_ticks;
	logic [4:0]  switch_slot;

	bit          slot_bound[SLOTS];
	bit          quiet_phase;
	bit          in_taken;
	bit          cfg_taken;
	bit          hold_go;
	int          hold_left;
	int          gap_left;
	int          stall_left;
	int          error_count;
	int          cycle_count;
	int          seen_expiry;
	int          seen_switch;
	int          seen_alloc;
	int          seen_refused;
	int          requests_done;

	sorted_timer_queue_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.timer_slot(timer_slot), .fifo_id(fifo_id), .data_value(data_value),
		.delay(delay), .out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .result_slot(result_slot),
		.target_fifo(target_fifo), .payload(payload), .granted(granted),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
		error_count++;
	endtask

	function automatic result_t make_result(logic [1:0] kind, logic [3:0] slot,
			logic [7:0] fifo, logic [31:0] data, logic grant);
		result_t r;
		r.kind = kind;
		r.slot = slot;
		r.fifo = fifo;
		r.data = data;
		r.grant = grant;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic unlink_timer(input int s);
		int prev;
		int cur;
		prev = SLOTS;
		cur = int'(pool_head);
		for (int n = 0; n < SLOTS && cur < SLOTS; n++) begin
			if (cur == s) begin
				if (prev == SLOTS) pool_head = pool_link[cur];
				else pool_link[prev] = pool_link[cur];
				return;
			end
			prev = cur;
			cur = int'(pool_link[cur]);
		end
	endtask

	task automatic insert_timer(input int s);
		int prev;
		int cur;
		prev = SLOTS;
		cur = int'(pool_head);
		for (int n = 0; n < SLOTS && cur < SLOTS; n++) begin
			if (pool_expiry[s] <= pool_expiry[cur]) break;
			prev = cur;
			cur = int'(pool_link[cur]);
		end
		if (cur >= SLOTS) cur = SLOTS;
		pool_link[s] = cur[4:0];
		if (prev == SLOTS) pool_head = s[4:0];
		else pool_link[prev] = s[4:0];
	endtask

	task automatic predict_timer_results(input request_t rq);
		result_t run[$];
		bit      want_switch;
		bit      found;
		int      h;
		want_switch = 0;
		found = 0;
		case (rq.mode)
			MODE_TICK: begin
				pool_ticks = pool_ticks + 32'd1;
				for (int n = 0; n < SLOTS && pool_head < SLOTS; n++) begin
					h = int'(pool_head);
					if (pool_expiry[h] > pool_ticks) break;
					pool_head = pool_link[h];
					pool_status[h] = ST_ALLOC;
					if (h == switch_slot) want_switch = 1;
					else run.push_back(make_result(KIND_EXPIRY, h[3:0], pool_fifo[h],
						pool_data[h], 1'b0));
				end
				if (want_switch) run.push_back(make_result(KIND_SWITCH, 4'd0, 8'd0,
					32'd0, 1'b0));
			end
			MODE_ALLOC: begin
				for (int i = 0; i < SLOTS && !found; i++) begin
					if (pool_status[i] == ST_FREE) begin
						pool_status[i] = ST_ALLOC;
						run.push_back(make_result(KIND_ALLOC, i[3:0], 8'd0, 32'd0, 1'b1));
						found = 1;
					end
				end
				if (!found) run.push_back(make_result(KIND_ALLOC, 4'd0, 8'd0, 32'd0, 1'b0));
			end
			MODE_BIND: begin
				pool_fifo[rq.slot] = rq.fifo;
				pool_data[rq.slot] = rq.data;
			end
			MODE_ARM: begin
				unlink_timer(int'(rq.slot));
				pool_expiry[rq.slot] = rq.delay + pool_ticks;
				pool_status[rq.slot] = ST_USING;
				insert_timer(int'(rq.slot));
			end
			MODE_RELEASE: pool_status[rq.slot] = ST_FREE;
			default: ;
		endcase
		if (run.size() > 0) run[run.size() - 1].last = 1'b1;
		foreach (run[i]) expected_results.push_back(run[i]);
	endtask

	// Monitor: records handshakes, updates the prediction and checks outputs.
	always @(posedge clk) begin
		request_t rq;
		result_t  want;
		in_taken = in_valid && !in_stall;
		cfg_taken = cfg_valid && cfg_ready;
		if (cfg_taken) switch_slot = cfg_data;
		if (in_taken) begin
			rq.mode = mode;
			rq.slot = timer_slot;
			rq.fifo = fifo_id;
			rq.data = data_value;
			rq.delay = delay;
			predict_timer_results(rq);
			requests_done++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result word of kind", 32'(result_kind), 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (result_kind !== want.kind)
					report_mismatch("kind", 32'(result_kind), 32'(want.kind));
				if (result_slot !== want.slot)
					report_mismatch("slot", 32'(result_slot), 32'(want.slot));
				if (target_fifo !== want.fifo)
					report_mismatch("fifo", 32'(target_fifo), 32'(want.fifo));
				if (payload !== want.data) report_mismatch("payload", payload, want.data);
				if (granted !== want.grant)
					report_mismatch("granted", 32'(granted), 32'(want.grant));
				if (last_of_run !== want.last)
					report_mismatch("last", 32'(last_of_run), 32'(want.last));
				if (want.kind == KIND_EXPIRY) seen_expiry++;
				if (want.kind == KIND_SWITCH) seen_switch++;
				if (want.kind == KIND_ALLOC && want.grant) seen_alloc++;
				if (want.kind == KIND_ALLOC && !want.grant) seen_refused++;
			end
		end
	end

	// Driver: offers pending requests with random gaps.
	always @(negedge clk) begin
		request_t rq;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			in_valid <= 1'b1;
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_requests.size() > 0) begin
			rq = pending_requests.pop_front();
			in_valid <= 1'b1;
			mode <= rq.mode;
			timer_slot <= rq.slot;
			fifo_id <= rq.fifo;
			data_value <= rq.data;
			delay <= rq.delay;
			if (quiet_phase) gap_left <= 0;
			else if ($urandom_range(0, 9) < 8) gap_left <= $urandom_range(0, 2);
			else gap_left <= $urandom_range(5, 40);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver back pressure, including one long hold-off.
	always @(negedge clk) begin
		if (hold_go) hold_left <= 400;
		else if (hold_left > 0) hold_left <= hold_left - 1;
		if (hold_left > 0 || hold_go) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				: $urandom_range(5, 40);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic add_request(input logic [2:0] m, input logic [3:0] s,
			input logic [7:0] f, input logic [31:0] d, input logic [31:0] dl);
		request_t rq;
		rq.mode = m;
		rq.slot = s;
		rq.fifo = f;
		rq.data = d;
		rq.delay = dl;
		pending_requests.push_back(rq);
		if (m == MODE_BIND) slot_bound[s] = 1;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_switch_slot(input logic [4:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_taken) @(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_random_requests(input int count);
		int          pick;
		logic [3:0]  s;
		logic [31:0] dl;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			s = 4'($urandom_range(0, SLOTS - 1));
			if ($urandom_range(0, 9) < 7) dl = $urandom_range(0, 8);
			else if ($urandom_range(0, 1) == 0) dl = $urandom_range(0, 100);
			else dl = $urandom;
			if (pick < 32) begin
				add_request(MODE_TICK, 4'($urandom), 8'($urandom), $urandom, $urandom);
			end else if (pick < 60) begin
				if (!slot_bound[s] || $urandom_range(0, 3) == 0)
					add_request(MODE_BIND, s, 8'($urandom), $urandom, $urandom);
				add_request(MODE_ARM, s, 8'($urandom), $urandom, dl);
			end else if (pick < 72) begin
				add_request(MODE_BIND, s, 8'($urandom), $urandom, $urandom);
			end else if (pick < 86) begin
				add_request(MODE_ALLOC, 4'($urandom), 8'($urandom), $urandom, $urandom);
			end else if (pick < 96) begin
				add_request(MODE_RELEASE, s, 8'($urandom), $urandom, $urandom);
			end else begin
				add_request(3'($urandom_range(5, 7)), 4'($urandom), 8'($urandom),
					$urandom, $urandom);
			end
		end
	endtask

	initial begin
		logic [4:0] settings[5];
		settings = '{5'd0, 5'd15, 5'd7, 5'd31, 5'd16};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = '0;
		timer_slot = '0;
		fifo_id = '0;
		data_value = '0;
		delay = '0;
		out_stall = 1'b0;
		hold_go = 0;
		quiet_phase = 0;
		foreach (pool_status[i]) begin
			pool_status[i] = ST_FREE;
			pool_expiry[i] = '0;
			pool_data[i] = '0;
			pool_fifo[i] = '0;
			pool_link[i] = '0;
		end
		pool_head = 5'(SLOTS);
		pool_ticks = '0;
		switch_slot = 5'd16;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: exhaust the pool, then equal deadlines, a repair and a
		// release of a queued slot.
		for (int i = 0; i <= SLOTS; i++)
			add_request(MODE_ALLOC, 4'd0, 8'd0, 32'd0, 32'd0);
		add_request(MODE_BIND, 4'd0, 8'hff, 32'hffffffff, 32'd0);
		add_request(MODE_BIND, 4'd15, 8'h00, 32'h00000000, 32'hffffffff);
		add_request(MODE_BIND, 4'd3, 8'h5a, 32'h12345678, 32'd0);
		add_request(MODE_ARM, 4'd0, 8'd0, 32'd0, 32'd0);
		add_request(MODE_ARM, 4'd15, 8'd0, 32'd0, 32'd1);
		add_request(MODE_ARM, 4'd3, 8'd0, 32'd0, 32'd1);
		add_request(MODE_ARM, 4'd0, 8'd0, 32'd0, 32'd2);
		add_request(MODE_RELEASE, 4'd15, 8'd0, 32'd0, 32'd0);
		add_request(3'd5, 4'd15, 8'hff, 32'hffffffff, 32'hffffffff);
		add_request(3'd7, 4'd0, 8'd0, 32'd0, 32'd0);
		add_request(MODE_TICK, 4'd0, 8'd0, 32'd0, 32'd0);
		add_request(MODE_TICK, 4'd0, 8'd0, 32'd0, 32'd0);
		add_request(MODE_ARM, 4'd3, 8'd0, 32'd0, 32'hffffffff);
		add_request(MODE_TICK, 4'd0, 8'd0, 32'd0, 32'd0);
		wait_idle();

		foreach (settings[p]) begin
			write_switch_slot(settings[p]);
			quiet_phase = (p == 2);
			if (p == 1) begin
				@(negedge clk);
				hold_go = 1;
				@(negedge clk);
				hold_go = 0;
			end
			add_random_requests(40);
			wait_idle();
		end

		$display("covered %0d requests: %0d grants, %0d refusals, %0d expiries,",
			requests_done, seen_alloc, seen_refused, seen_expiry);
		$display("%0d task switch requests over five switch slot settings", seen_switch);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
